@@ design/block_chain_extent_walker_assert.svh @@
// Assertion macros used by the walker controller.
`ifndef BLOCK_CHAIN_EXTENT_WALKER_ASSERT_SVH
`define BLOCK_CHAIN_EXTENT_WALKER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BCEW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcew assertion failed");
// Next-cycle implication, disabled during reset.
`define BCEW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcew assertion failed");
`else
`define BCEW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BCEW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/bcew_pkg.sv @@
package bcew_pkg;

   localparam int DATA_W          = 32;
   localparam int INDEX_W         = 5;
   localparam int START_W         = 16;
   localparam int TABLE_LEN_W     = 6;
   localparam int FILE_OFFSET_W   = 15;
   localparam int STREAM_OFFSET_W = 33;
   localparam int EXTENT_LEN_W    = 10;
   localparam int STATUS_W        = 2;
   localparam int PADDR_W         = 3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_WALK = 1'b1;

   localparam logic KIND_EXTENT = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_SHORT   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_CORRUPT = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_LOOP    = 2'd3;

   localparam logic REG_TABLE_LENGTH = 1'b0;
   localparam logic REG_END_MARKER   = 1'b1;

   typedef struct packed {
      logic start;
      logic load;
      logic step;
      logic emit_ext;
      logic emit_stat;
   } cmd_type;

   typedef struct packed {
      logic finish;
      logic skip_blk;
   } sts_type;

endpackage

@@ design/bcew_datapath.sv @@
module bcew_datapath #(
   parameter int TABLE_DEPTH = 32,
   parameter int BLOCK_BYTES = 512
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  bcew_pkg::cmd_type                           cmd,
   output bcew_pkg::sts_type                           sts,
   input  logic [bcew_pkg::INDEX_W-1:0]                req_entry_index,
   input  logic signed [bcew_pkg::DATA_W-1:0]          req_entry_next,
   input  logic [bcew_pkg::DATA_W-1:0]                 req_first_offset,
   input  logic [bcew_pkg::DATA_W-1:0]                 req_total_length,
   input  logic                                        req_until_end,
   input  logic [bcew_pkg::START_W-1:0]                req_start_block,
   input  logic [bcew_pkg::TABLE_LEN_W-1:0]            table_length,
   input  logic signed [bcew_pkg::DATA_W-1:0]          end_marker,
   output logic                                        rsp_kind,
   output logic [bcew_pkg::FILE_OFFSET_W-1:0]          rsp_file_offset,
   output logic [bcew_pkg::STREAM_OFFSET_W-1:0]        rsp_stream_offset,
   output logic [bcew_pkg::EXTENT_LEN_W-1:0]           rsp_extent_length,
   output logic [bcew_pkg::STATUS_W-1:0]               rsp_status,
   output logic [bcew_pkg::DATA_W-1:0]                 rsp_remaining,
   output logic                                        rsp_last
);

   localparam int MAX_WRITABLE = 2 ** bcew_pkg::INDEX_W;
   localparam int MEM_DEPTH = (TABLE_DEPTH < MAX_WRITABLE) ? TABLE_DEPTH : MAX_WRITABLE;
   localparam int MIDX_W = $clog2(MEM_DEPTH);
   localparam int STEP_W = $clog2(TABLE_DEPTH + 1);
   localparam int BB_W = $clog2(BLOCK_BYTES + 1);
   localparam int BLK_W = bcew_pkg::TABLE_LEN_W + 1;
   localparam int PROD_W = BLK_W + BB_W;
   localparam int DW = bcew_pkg::DATA_W;
   localparam logic [DW-1:0] BB32 = DW'(BLOCK_BYTES);
   localparam logic [DW-1:0] TD32 = DW'(TABLE_DEPTH);

   logic [DW-1:0] mem [MEM_DEPTH];

   logic [DW-1:0]                          rd_ff;
   logic                                   sel_mem_ff, sel_mem_in;
   logic [STEP_W-1:0]                      step_ff, step_in;
   logic [DW-1:0]                          skip_ff, skip_in;
   logic [DW-1:0]                          togo_ff, togo_in;
   logic [bcew_pkg::STREAM_OFFSET_W-1:0]   nso_ff, nso_in;
   logic                                   all_ff, all_in;
   logic [bcew_pkg::START_W-1:0]           start_ff, start_in;

   logic [DW-1:0]          cur;
   logic [DW-1:0]          tl32;
   logic [DW-1:0]          limit;
   logic                   at_end, len_done, guard, bad;
   logic [bcew_pkg::STATUS_W-1:0] fin_status;
   logic [DW-1:0]          room;
   logic [DW-1:0]          len;
   logic [BLK_W-1:0]       blk_plus;
   logic [PROD_W-1:0]      prod;
   logic [DW-1:0]          fo_full;

   // Current block: the start block first, then each registered table read.
   assign cur = sel_mem_ff ? rd_ff : {{(DW - bcew_pkg::START_W){1'b0}}, start_ff};

   assign tl32  = {{(DW - bcew_pkg::TABLE_LEN_W){1'b0}}, table_length};
   assign limit = (tl32 < TD32) ? tl32 : TD32;

   assign at_end   = (cur == $unsigned(end_marker));
   assign len_done = !all_ff && (togo_ff == '0);
   assign guard    = (step_ff >= STEP_W'(TABLE_DEPTH));
   assign bad      = (cur >= limit);

   assign sts.finish   = at_end || len_done || guard || bad;
   assign sts.skip_blk = (skip_ff >= BB32);

   always_comb begin
      if (at_end) begin
         fin_status = (all_ff || (togo_ff == '0)) ? bcew_pkg::STAT_OK : bcew_pkg::STAT_SHORT;
      end else if (len_done) begin
         fin_status = bcew_pkg::STAT_OK;
      end else if (guard) begin
         fin_status = bcew_pkg::STAT_LOOP;
      end else begin
         fin_status = bcew_pkg::STAT_CORRUPT;
      end
   end

   assign room = BB32 - skip_ff;
   assign len  = (!all_ff && (togo_ff < room)) ? togo_ff : room;

   // A block that is emitted lies below the limit, so its low bits suffice.
   assign blk_plus = {1'b0, cur[bcew_pkg::TABLE_LEN_W-1:0]} + BLK_W'(1);
   assign prod     = {{BB_W{1'b0}}, blk_plus} * PROD_W'(BLOCK_BYTES);
   assign fo_full  = DW'(prod) + skip_ff;

   // Table storage.
   always_ff @(posedge clock) begin
      if (cmd.load && ({{(DW - bcew_pkg::INDEX_W){1'b0}}, req_entry_index} < TD32)) begin
         mem[req_entry_index[MIDX_W-1:0]] <= $unsigned(req_entry_next);
      end
      if (cmd.step) begin
         rd_ff <= mem[cur[MIDX_W-1:0]];
      end
   end

   always_comb begin
      sel_mem_in = sel_mem_ff;
      step_in    = step_ff;
      skip_in    = skip_ff;
      togo_in    = togo_ff;
      nso_in     = nso_ff;
      all_in     = all_ff;
      start_in   = start_ff;
      if (cmd.start) begin
         sel_mem_in = 1'b0;
         step_in    = '0;
         skip_in    = req_first_offset;
         togo_in    = req_until_end ? '0 : req_total_length;
         nso_in     = {1'b0, req_first_offset};
         all_in     = req_until_end;
         start_in   = req_start_block;
      end else if (cmd.step) begin
         sel_mem_in = 1'b1;
         step_in    = step_ff + STEP_W'(1);
         if (sts.skip_blk) begin
            skip_in = skip_ff - BB32;
         end else begin
            skip_in = '0;
            nso_in  = nso_ff + {1'b0, len};
            if (!all_ff) begin
               togo_in = togo_ff - len;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_mem_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         sel_mem_ff <= sel_mem_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      skip_ff  <= skip_in;
      togo_ff  <= togo_in;
      nso_ff   <= nso_in;
      all_ff   <= all_in;
      start_ff <= start_in;
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (cmd.emit_ext) begin
         rsp_kind          <= bcew_pkg::KIND_EXTENT;
         rsp_file_offset   <= fo_full[bcew_pkg::FILE_OFFSET_W-1:0];
         rsp_stream_offset <= nso_ff;
         rsp_extent_length <= len[bcew_pkg::EXTENT_LEN_W-1:0];
         rsp_status        <= bcew_pkg::STAT_OK;
         rsp_remaining     <= '0;
         rsp_last          <= 1'b0;
      end else if (cmd.emit_stat) begin
         rsp_kind          <= bcew_pkg::KIND_STATUS;
         rsp_file_offset   <= '0;
         rsp_stream_offset <= nso_ff;
         rsp_extent_length <= '0;
         rsp_status        <= fin_status;
         rsp_remaining     <= all_ff ? '0 : togo_ff;
         rsp_last          <= 1'b1;
      end
   end

endmodule

@@ design/bcew_ctrl.sv @@
`include "block_chain_extent_walker_assert.svh"

module bcew_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_operation,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  bcew_pkg::sts_type  sts,
   output bcew_pkg::cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == bcew_pkg::OP_WALK) begin
                  cmd.start = 1'b1;
                  state_in  = S_WALK;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_WALK: begin
            if (sts.finish) begin
               if (slot_free) begin
                  cmd.emit_stat = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (sts.skip_blk) begin
               cmd.step = 1'b1;
            end else if (slot_free) begin
               cmd.step     = 1'b1;
               cmd.emit_ext = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_ext || cmd.emit_stat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BCEW_ASSERT_IMPL(a_emit_slot, clock, reset, (cmd.emit_ext || cmd.emit_stat), slot_free)
   `BCEW_ASSERT_IMPL(a_no_accept_walk, clock, reset, (state_ff == S_WALK), !req_ready)
   `BCEW_ASSERT_NEXT(a_stat_ends_walk, clock, reset, cmd.emit_stat, (state_ff == S_IDLE))
   `BCEW_ASSERT_NEXT(a_start_walks, clock, reset, cmd.start, (state_ff == S_WALK))

endmodule

@@ design/block_chain_extent_walker.sv @@
// Load item: accepted while idle, gives no result, loads may follow back to back. Walk:
// accepted while idle, then steps through one registered table read per visited block and
// ends with a status item; one request in flight at a time.
// An extent or status item that is not taken stalls the walk at the next emitted item.
// Reset (synchronous, active high) idles the controller, drops rsp_valid and sets
// table_length to 32 and end_marker to -2; table entries stay undefined until written.
module block_chain_extent_walker #(
   parameter int TABLE_DEPTH = 32,
   parameter int BLOCK_BYTES = 512
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_operation,
   input  logic [bcew_pkg::INDEX_W-1:0]             req_entry_index,
   input  logic signed [bcew_pkg::DATA_W-1:0]       req_entry_next,
   input  logic [bcew_pkg::DATA_W-1:0]              req_first_offset,
   input  logic [bcew_pkg::DATA_W-1:0]              req_total_length,
   input  logic                                     req_until_end,
   input  logic [bcew_pkg::START_W-1:0]             req_start_block,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_kind,
   output logic [bcew_pkg::FILE_OFFSET_W-1:0]       rsp_file_offset,
   output logic [bcew_pkg::STREAM_OFFSET_W-1:0]     rsp_stream_offset,
   output logic [bcew_pkg::EXTENT_LEN_W-1:0]        rsp_extent_length,
   output logic [bcew_pkg::STATUS_W-1:0]            rsp_status,
   output logic [bcew_pkg::DATA_W-1:0]              rsp_remaining,
   output logic                                     rsp_last,
   // register port
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [bcew_pkg::PADDR_W-1:0]             paddr,
   input  logic [bcew_pkg::DATA_W-1:0]              pwdata,
   output logic [bcew_pkg::DATA_W-1:0]              prdata,
   output logic                                     pready
);

   // Register file: table_length at byte 0, end_marker at byte 4.
   logic [bcew_pkg::TABLE_LEN_W-1:0]       table_length_ff, table_length_in;
   logic signed [bcew_pkg::DATA_W-1:0]     end_marker_ff, end_marker_in;
   logic                                   reg_sel;
   logic                                   reg_wr;

   bcew_pkg::cmd_type cmd;
   bcew_pkg::sts_type sts;

   // No wait states on the register port.
   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign reg_wr  = psel && penable && pwrite && pready;

   always_comb begin
      table_length_in = table_length_ff;
      end_marker_in   = end_marker_ff;
      prdata          = '0;
      unique case (reg_sel)
         bcew_pkg::REG_TABLE_LENGTH: begin
            prdata = {{(bcew_pkg::DATA_W - bcew_pkg::TABLE_LEN_W){1'b0}}, table_length_ff};
            if (reg_wr) begin
               table_length_in = pwdata[bcew_pkg::TABLE_LEN_W-1:0];
            end
         end
         bcew_pkg::REG_END_MARKER: begin
            prdata = $unsigned(end_marker_ff);
            if (reg_wr) begin
               end_marker_in = $signed(pwdata);
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= bcew_pkg::TABLE_LEN_W'(32);
         end_marker_ff   <= -32'sd2;
      end else begin
         table_length_ff <= table_length_in;
         end_marker_ff   <= end_marker_in;
      end
   end

   // Sequencer: accept transactions, step the chain, hand results to the output register.
   bcew_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // Datapath: table memory, walk registers, extent arithmetic, result payload.
   bcew_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_entry_index   (req_entry_index),
      .req_entry_next    (req_entry_next),
      .req_first_offset  (req_first_offset),
      .req_total_length  (req_total_length),
      .req_until_end     (req_until_end),
      .req_start_block   (req_start_block),
      .table_length      (table_length_ff),
      .end_marker        (end_marker_ff),
      .rsp_kind          (rsp_kind),
      .rsp_file_offset   (rsp_file_offset),
      .rsp_stream_offset (rsp_stream_offset),
      .rsp_extent_length (rsp_extent_length),
      .rsp_status        (rsp_status),
      .rsp_remaining     (rsp_remaining),
      .rsp_last          (rsp_last)
   );

endmodule

@@ bench/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DEPTH        = 32;
   localparam logic [31:0] BLOCK        = 32'd512;
   // A walk visits at most DEPTH blocks before its status item.
   localparam int          DRAIN_CYCLES = 40;
   localparam int          RANDOM_ITEMS = 340;

   typedef struct packed {
      logic                                operation;
      logic [bcew_pkg::INDEX_W-1:0]        entry_index;
      logic signed [bcew_pkg::DATA_W-1:0]  entry_next;
      logic [bcew_pkg::DATA_W-1:0]         first_offset;
      logic [bcew_pkg::DATA_W-1:0]         total_length;
      logic                                until_end;
      logic [bcew_pkg::START_W-1:0]        start_block;
   } chain_req_type;

   // One extent or final status transaction on the result channel.
   typedef struct packed {
      logic                                  kind;
      logic [bcew_pkg::FILE_OFFSET_W-1:0]    file_offset;
      logic [bcew_pkg::STREAM_OFFSET_W-1:0]  stream_offset;
      logic [bcew_pkg::EXTENT_LEN_W-1:0]     extent_length;
      logic [bcew_pkg::STATUS_W-1:0]         status;
      logic [bcew_pkg::DATA_W-1:0]           remaining;
      logic                                  last;
   } extent_type;

   // Clock, reset and every block input start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid        = 1'b0;
   logic                               req_ready;
   logic                               req_operation    = bcew_pkg::OP_LOAD;
   logic [bcew_pkg::INDEX_W-1:0]       req_entry_index  = '0;
   logic signed [bcew_pkg::DATA_W-1:0] req_entry_next   = '0;
   logic [bcew_pkg::DATA_W-1:0]        req_first_offset = '0;
   logic [bcew_pkg::DATA_W-1:0]        req_total_length = '0;
   logic                               req_until_end    = 1'b0;
   logic [bcew_pkg::START_W-1:0]       req_start_block  = '0;

   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b1;
   logic                                 rsp_kind;
   logic [bcew_pkg::FILE_OFFSET_W-1:0]   rsp_file_offset;
   logic [bcew_pkg::STREAM_OFFSET_W-1:0] rsp_stream_offset;
   logic [bcew_pkg::EXTENT_LEN_W-1:0]    rsp_extent_length;
   logic [bcew_pkg::STATUS_W-1:0]        rsp_status;
   logic [bcew_pkg::DATA_W-1:0]          rsp_remaining;
   logic                                 rsp_last;

   logic                         psel    = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite  = 1'b0;
   logic [bcew_pkg::PADDR_W-1:0] paddr   = '0;
   logic [bcew_pkg::DATA_W-1:0]  pwdata  = '0;
   logic [bcew_pkg::DATA_W-1:0]  prdata;
   logic                         pready;

   // Shadow of the block: next-block table and the two registers.
   logic [31:0]                      chain_copy [0:DEPTH-1];
   logic [bcew_pkg::TABLE_LEN_W-1:0] tbl_len_copy  = 6'd32;
   logic [31:0]                      end_mark_copy = 32'hFFFF_FFFE;

   chain_req_type req_backlog [$];   // request transactions not yet presented
   extent_type    extents_due [$];   // extents and status items still to arrive
   chain_req_type next_req;

   int   items_queued = 0;
   int   errors       = 0;
   int   gap_left     = 0;
   int   req_calm     = 0;
   int   stall_left   = 0;
   int   rsp_calm     = 0;
   logic req_accepted = 1'b0;

   // Chain laid out by the current phase, used to aim walks at real blocks.
   int chain_blocks [0:DEPTH-1];
   int chain_len = 0;

   block_chain_extent_walker uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_entry_next    (req_entry_next),
      .req_first_offset  (req_first_offset),
      .req_total_length  (req_total_length),
      .req_until_end     (req_until_end),
      .req_start_block   (req_start_block),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_file_offset   (rsp_file_offset),
      .rsp_stream_offset (rsp_stream_offset),
      .rsp_extent_length (rsp_extent_length),
      .rsp_status        (rsp_status),
      .rsp_remaining     (rsp_remaining),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Pause length: mostly none or short, now and then a long one.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Walk the shadow chain and queue every extent plus the closing status item.
   task automatic predict_walk(input logic [bcew_pkg::DATA_W-1:0] offset,
                               input logic [bcew_pkg::DATA_W-1:0] want,
                               input logic to_end,
                               input logic [bcew_pkg::START_W-1:0] start);
      logic [31:0]                          blk;
      logic [31:0]                          skip;
      logic [31:0]                          to_go;
      logic [31:0]                          limit;
      logic [31:0]                          len;
      logic [31:0]                          fo;
      logic [bcew_pkg::STREAM_OFFSET_W-1:0] sofs;
      logic [bcew_pkg::STATUS_W-1:0]        st;
      int                                   steps;
      bit                                   done;
      extent_type                           item;
      blk   = {16'd0, start};
      skip  = offset;
      to_go = to_end ? 32'd0 : want;
      sofs  = {1'b0, offset};
      steps = 0;
      done  = 1'b0;
      st    = bcew_pkg::STAT_OK;
      limit = {26'd0, tbl_len_copy};
      if (limit > 32'(DEPTH)) limit = 32'(DEPTH);
      while (!done) begin
         if (blk == end_mark_copy) begin
            st   = (to_end || to_go == 32'd0) ? bcew_pkg::STAT_OK : bcew_pkg::STAT_SHORT;
            done = 1'b1;
         end else if (!to_end && to_go == 32'd0) begin
            st   = bcew_pkg::STAT_OK;
            done = 1'b1;
         end else if (steps >= DEPTH) begin
            st   = bcew_pkg::STAT_LOOP;
            done = 1'b1;
         end else if (blk >= limit) begin
            st   = bcew_pkg::STAT_CORRUPT;
            done = 1'b1;
         end else begin
            steps++;
            if (skip >= BLOCK) begin
               skip = skip - BLOCK;
            end else begin
               len = BLOCK - skip;
               if (!to_end && to_go < len) len = to_go;
               fo                 = (blk + 32'd1) * BLOCK + skip;
               item               = '0;
               item.kind          = bcew_pkg::KIND_EXTENT;
               item.file_offset   = fo[bcew_pkg::FILE_OFFSET_W-1:0];
               item.stream_offset = sofs;
               item.extent_length = len[bcew_pkg::EXTENT_LEN_W-1:0];
               extents_due.push_back(item);
               skip = 32'd0;
               sofs = sofs + {1'b0, len};
               if (!to_end) to_go = to_go - len;
            end
            blk = chain_copy[blk[bcew_pkg::INDEX_W-1:0]];
         end
      end
      item               = '0;
      item.kind          = bcew_pkg::KIND_STATUS;
      item.stream_offset = sofs;
      item.status        = st;
      item.remaining     = to_end ? 32'd0 : to_go;
      item.last          = 1'b1;
      extents_due.push_back(item);
   endtask

   task automatic report_bad(input string what, input extent_type want, input extent_type got);
      errors++;
      if (errors <= 10)
         $display("%s at %0t: expected kind=%0d file=%0d stream=%0d len=%0d",
                  what, $realtime, want.kind, want.file_offset, want.stream_offset,
                  want.extent_length,
                  " status=%0d rem=%0d last=%0d,", want.status, want.remaining, want.last,
                  " got kind=%0d file=%0d stream=%0d len=%0d",
                  got.kind, got.file_offset, got.stream_offset, got.extent_length,
                  " status=%0d rem=%0d last=%0d", got.status, got.remaining, got.last);
   endtask

   task automatic check_result();
      extent_type got;
      extent_type want;
      got = {rsp_kind, rsp_file_offset, rsp_stream_offset, rsp_extent_length,
             rsp_status, rsp_remaining, rsp_last};
      if (extents_due.size() == 0) begin
         report_bad("result with nothing pending", '0, got);
      end else begin
         want = extents_due.pop_front();
         if (got !== want) report_bad("result mismatch", want, got);
      end
   endtask

   // Monitor: sample both channels at the rising edge. A load transaction
   // updates the shadow table, a walk transaction queues its predicted items.
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         if (req_operation == bcew_pkg::OP_LOAD)
            chain_copy[req_entry_index] = $unsigned(req_entry_next);
         else
            predict_walk(req_first_offset, req_total_length, req_until_end, req_start_block);
      end
      if (!reset && rsp_valid && rsp_ready) check_result();
   end

   // Driver: change request inputs on the falling edge only. Hold valid and
   // payload until the transaction is taken, then idle for the gap picked
   // with it, or advance straight to the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         // hold the current transaction
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (req_backlog.size() != 0) begin
         next_req = req_backlog.pop_front();
         req_valid        <= 1'b1;
         req_operation    <= next_req.operation;
         req_entry_index  <= next_req.entry_index;
         req_entry_next   <= next_req.entry_next;
         req_first_offset <= next_req.first_offset;
         req_total_length <= next_req.total_length;
         req_until_end    <= next_req.until_end;
         req_start_block  <= next_req.start_block;
         // Now and then run a calm stretch of back-to-back transactions.
         if (req_calm > 0) begin
            req_calm <= req_calm - 1;
            gap_left <= 0;
         end else begin
            gap_left <= pick_pause();
            if ($urandom_range(0, 49) == 0) req_calm <= 40;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side: drop ready for random stalls, with calm stretches too.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_calm > 0) begin
            rsp_calm <= rsp_calm - 1;
         end else begin
            stall_left <= pick_pause();
            if ($urandom_range(0, 49) == 0) rsp_calm <= 40;
         end
      end
   end

   task automatic queue_load(input logic [bcew_pkg::INDEX_W-1:0] idx,
                             input logic [bcew_pkg::DATA_W-1:0] nxt);
      chain_req_type item;
      item.operation    = bcew_pkg::OP_LOAD;
      item.entry_index  = idx;
      item.entry_next   = $signed(nxt);
      item.first_offset = $urandom;
      item.total_length = $urandom;
      item.until_end    = 1'($urandom_range(0, 1));
      item.start_block  = 16'($urandom);
      req_backlog.push_back(item);
      items_queued++;
   endtask

   task automatic queue_walk(input logic [bcew_pkg::START_W-1:0] start,
                             input logic [bcew_pkg::DATA_W-1:0] offset,
                             input logic [bcew_pkg::DATA_W-1:0] want, input logic to_end);
      chain_req_type item;
      item.operation    = bcew_pkg::OP_WALK;
      item.entry_index  = 5'($urandom);
      item.entry_next   = $signed($urandom);
      item.first_offset = offset;
      item.total_length = want;
      item.until_end    = to_end;
      item.start_block  = start;
      req_backlog.push_back(item);
      items_queued++;
   endtask

   // Wait until the block is idle: nothing left to send, nothing due back,
   // then let a full walk's worth of cycles pass for a trailing load.
   task automatic wait_quiet();
      while (req_backlog.size() != 0 || req_valid || extents_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle; the write lands at the
   // rising edge with penable and pready high.
   task automatic csr_write(input logic reg_index, input logic [bcew_pkg::DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_index == bcew_pkg::REG_TABLE_LENGTH)
         tbl_len_copy = data[bcew_pkg::TABLE_LEN_W-1:0];
      else
         end_mark_copy = data;
   endtask

   // Lay out one chain through valid, non-marker entries in shuffled order and
   // close it with the end marker, a loop back, a bad index or random noise.
   task automatic build_chain();
      int          pool [$];
      int          limit;
      int          j;
      int          t;
      int          r;
      logic [31:0] tail;
      limit = (tbl_len_copy > 6'(DEPTH)) ? DEPTH : int'(tbl_len_copy);
      pool  = {};
      for (int i = 0; i < limit; i++)
         if (32'(i) != end_mark_copy) pool.push_back(i);
      for (int i = pool.size() - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         t       = pool[i];
         pool[i] = pool[j];
         pool[j] = t;
      end
      if (pool.size() == 0) begin
         chain_len = 0;
      end else if ($urandom_range(0, 4) == 0) begin
         chain_len = pool.size();
      end else begin
         t         = (pool.size() < 10) ? pool.size() : 10;
         chain_len = $urandom_range(1, t);
      end
      for (int i = 0; i < chain_len; i++) begin
         chain_blocks[i] = pool[i];
         if (i < chain_len - 1) queue_load(5'(pool[i]), 32'(pool[i + 1]));
      end
      if (chain_len > 0) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            tail = end_mark_copy;
         end else if (r < 80) begin
            tail = 32'(pool[$urandom_range(0, chain_len - 1)]);
         end else if (r < 92) begin
            tail = 32'(limit) + 32'($urandom_range(0, 200));
            if (tail == end_mark_copy) tail = tail + 32'd1;
         end else begin
            tail = $urandom;
         end
         queue_load(5'(pool[chain_len - 1]), tail);
      end
   endtask

   // Mostly walks that start on the chain with offsets and lengths near its
   // size; the rest start on the marker or anywhere, with any offset.
   task automatic random_walk();
      logic [bcew_pkg::START_W-1:0] start;
      logic [bcew_pkg::DATA_W-1:0]  offset;
      logic [bcew_pkg::DATA_W-1:0]  want;
      int                           span;
      int                           r;
      span = (chain_len + 1) * 512;
      r = $urandom_range(0, 99);
      if (chain_len > 0 && r < 80) start = 16'(chain_blocks[$urandom_range(0, chain_len - 1)]);
      else if (r < 90)             start = end_mark_copy[bcew_pkg::START_W-1:0];
      else                         start = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 55)      offset = 32'($urandom_range(0, span));
      else if (r < 75) offset = 32'($urandom_range(0, 511));
      else if (r < 85) offset = 32'(512 * $urandom_range(0, chain_len + 1));
      else if (r < 92) offset = 32'd0;
      else             offset = $urandom;
      r = $urandom_range(0, 99);
      if (r < 10)      want = 32'd0;
      else if (r < 45) want = 32'($urandom_range(1, 600));
      else if (r < 80) want = 32'($urandom_range(1, span));
      else             want = $urandom;
      queue_walk(start, offset, want, $urandom_range(0, 3) == 0);
   endtask

   initial begin
      int                               directed_items;
      int                               phase;
      int                               r;
      logic [bcew_pkg::TABLE_LEN_W-1:0] tl;
      logic [31:0]                      em;
      logic [31:0]                      data;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill every table entry first: one straight chain 0 -> 1 -> ... -> 31
      // that ends on the reset end marker. No walk ever reads an unwritten entry.
      for (int i = 0; i < DEPTH; i++)
         queue_load(5'(i), (i == DEPTH - 1) ? end_mark_copy : 32'(i + 1));

      // Directed walks on the full chain, reset configuration.
      queue_walk(16'd0, 32'd0, 32'd0, 1'b0);              // zero length: status only
      queue_walk(16'd0, 32'd0, 32'd0, 1'b1);              // whole chain, most results
      queue_walk(16'd3, 32'd700, 32'd1000, 1'b0);         // skip then partial blocks
      queue_walk(16'd28, 32'd100, 32'd5000, 1'b0);        // chain ends short
      queue_walk(16'hFFFF, 32'd0, 32'd10, 1'b0);          // start on a bad index
      queue_walk(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);  // skip everything, short
      queue_walk(16'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);      // skip everything, until end
      queue_walk(16'd31, 32'd511, 32'd1, 1'b0);           // top file offset, one byte
      queue_walk(16'd0, 32'd1024, 32'd512, 1'b0);         // exactly one aligned block
      queue_walk(16'd30, 32'd0, 32'd1024, 1'b0);          // length ends on chain end
      // Close the chain into a loop: loop guard with emits and with skips only.
      queue_load(5'd31, 32'd0);
      queue_walk(16'd0, 32'd0, 32'd0, 1'b1);
      queue_walk(16'd5, 32'd20480, 32'd0, 1'b1);
      // Corrupt links at the signed extremes and at minus one.
      queue_load(5'd10, 32'h7FFF_FFFF);
      queue_walk(16'd8, 32'd0, 32'd3000, 1'b0);
      queue_load(5'd10, 32'h8000_0000);
      queue_walk(16'd9, 32'd0, 32'd0, 1'b1);
      queue_load(5'd10, 32'hFFFF_FFFF);
      queue_walk(16'd10, 32'd512, 32'd2000, 1'b0);
      // Restore the straight chain.
      queue_load(5'd10, 32'd11);
      queue_load(5'd31, end_mark_copy);
      queue_walk(16'hFFFE, 32'd0, 32'd1, 1'b0);
      directed_items = items_queued;

      // Random phases: reconfigure while idle, lay out a chain, then walk it
      // with some noise loads mixed in. Every phase boundary drains the block.
      phase = 0;
      while (items_queued - directed_items < RANDOM_ITEMS) begin
         wait_quiet();
         case (phase)
            0: begin
               tl = 6'd63;
               em = 32'h8000_0000;
            end
            1: begin
               tl = 6'd0;
               em = 32'h7FFF_FFFF;
            end
            2: begin
               tl = 6'd5;
               em = 32'd3;
            end
            default: begin
               r = $urandom_range(0, 99);
               if (r < 30)      tl = 6'd32;
               else if (r < 45) tl = 6'd63;
               else if (r < 50) tl = 6'd0;
               else if (r < 80) tl = 6'($urandom_range(1, 31));
               else             tl = 6'($urandom_range(33, 62));
               case ($urandom_range(0, 6))
                  0:       em = 32'hFFFF_FFFE;
                  1:       em = 32'hFFFF_FFFF;
                  2:       em = 32'd0;
                  3:       em = 32'h7FFF_FFFF;
                  4:       em = 32'h8000_0000;
                  5:       em = 32'($urandom_range(0, 40));
                  default: em = $urandom;
               endcase
            end
         endcase
         // Upper bits of the length write are junk; only six bits count.
         data      = $urandom;
         data[5:0] = tl;
         csr_write(bcew_pkg::REG_TABLE_LENGTH, data);
         csr_write(bcew_pkg::REG_END_MARKER, em);
         build_chain();
         repeat (30) begin
            if ($urandom_range(0, 99) < 15) queue_load(5'($urandom), $urandom);
            else                            random_walk();
         end
         phase++;
      end

      wait_quiet();
      if (errors == 0 && extents_due.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #200_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
